// File: hdl/pfifo_pkg.sv
// Shared types and constants for the prefetch FIFO with skid register.
// No dependencies; imported by every module in hdl/.
package pfifo_pkg;

    localparam int ADDR_BITS = 4;
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int WORD_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int TDATA_W   = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [ADDR_BITS-1:0] ptr_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // One cycle of FIFO stimulus, as unpacked from s_tdata.
    typedef struct packed {
        logic  pop_ready;
        word_t push_data;
        logic  push_req;
        logic  flush;
    } step_t;

    // FIFO outputs for one cycle; packs straight into m_tdata (head_data lowest).
    typedef struct packed {
        count_t occupancy;
        logic   is_empty;
        logic   is_full;
        logic   head_valid;
        word_t  head_data;
    } result_t;

endpackage

// File: hdl/prefetch_fifo_with_skid.sv
// Top level: stream wrapper around the prefetch FIFO core and its result register.
// Depends on pfifo_pkg, pfifo_core, pfifo_out.
//
//  channel  | direction | payload (tdata, lowest bit up)
//  ---------+-----------+-----------------------------------------------------------
//  s_       | in        | flush[0] push_req[1] push_data[17:2] pop_ready[18], pad to 24
//  m_       | out       | head_data[15:0] head_valid[16] is_full[17] is_empty[18]
//           |           | occupancy[23:19]
//
// Each input transfer is one FIFO cycle and yields one result transfer, registered at
// its edge. Throughput is one transfer per clock while s_tready is high: the core
// update, memory write and memory read into the read-word register share that edge.
// s_tready drops only while a result sits unaccepted with m_tready low.
// Reset (aresetn low, synchronous) empties the FIFO; memory contents are not cleared.
module prefetch_fifo_with_skid (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfifo_pkg::TDATA_W-1:0] s_tdata,  // flush, push_req, push_data, pop_ready
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfifo_pkg::TDATA_W-1:0] m_tdata   // head_data, head_valid, is_full,
                                                    // is_empty, occupancy
);
    import pfifo_pkg::*;

    step_t   step;
    result_t res;
    logic    step_en;

    assign step.flush     = s_tdata[0];
    assign step.push_req  = s_tdata[1];
    assign step.push_data = s_tdata[WORD_W+1:2];
    assign step.pop_ready = s_tdata[WORD_W+2];

    assign step_en = s_tvalid & s_tready;

    pfifo_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .step    (step),
        .res     (res)
    );

    pfifo_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_tvalid),
        .res        (res),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: hdl/pfifo_core.sv
// FIFO state: memory, pointers, read word, skid register and item count.
// Advances one FIFO cycle per accepted step. Depends on pfifo_pkg.
module pfifo_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  pfifo_pkg::step_t   step,
    output pfifo_pkg::result_t res
);
    import pfifo_pkg::*;

    word_t  mem [DEPTH];
    ptr_t   wr_ptr_reg, wr_ptr_next;
    ptr_t   rd_ptr_reg, rd_ptr_next;
    word_t  read_word_reg;
    logic   read_valid_reg, read_valid_next;
    word_t  skid_word_reg, skid_word_next;
    logic   skid_full_reg, skid_full_next;
    count_t occ_reg, occ_next;

    ptr_t   wr_inc, rd_inc;
    logic   empty, full, head_valid, we, re, handshake;

    assign wr_inc     = ptr_t'(wr_ptr_reg + 1'b1);
    assign rd_inc     = ptr_t'(rd_ptr_reg + 1'b1);
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_inc == rd_ptr_reg);
    assign head_valid = read_valid_reg | skid_full_reg;
    assign handshake  = step.pop_ready & head_valid;
    assign we         = step.push_req & ~full & ~step.flush;

    // Prefetch: with ready, keep up to two words staged; without, only refill when dry.
    always_comb begin
        re = 1'b0;
        if (!empty && !step.flush) begin
            if (step.pop_ready) begin
                re = ~(read_valid_reg & skid_full_reg);
            end else begin
                re = ~read_valid_reg & ~skid_full_reg;
            end
        end
    end

    always_comb begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        read_valid_next = read_valid_reg;
        skid_word_next  = skid_word_reg;
        skid_full_next  = skid_full_reg;
        occ_next        = occ_reg;
        if (step.flush) begin
            rd_ptr_next     = wr_ptr_reg;
            read_valid_next = 1'b0;
            skid_word_next  = '0;
            skid_full_next  = 1'b0;
            occ_next        = '0;
        end else begin
            if (we && !handshake) begin
                if (occ_reg != COUNT_MAX) occ_next = count_t'(occ_reg + 1'b1);
            end else if (!we && handshake) begin
                if (occ_reg != '0) occ_next = count_t'(occ_reg - 1'b1);
            end
            if (step.pop_ready && skid_full_reg) skid_full_next = 1'b0;
            // read word not taken directly parks in the skid register
            if (read_valid_reg && !(step.pop_ready && !skid_full_reg)) begin
                skid_full_next = 1'b1;
                skid_word_next = read_word_reg;
            end
            if (we) wr_ptr_next = wr_inc;
            if (re) rd_ptr_next = rd_inc;
            read_valid_next = re;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            read_valid_reg <= 1'b0;
            skid_word_reg  <= '0;
            skid_full_reg  <= 1'b0;
            occ_reg        <= '0;
        end else if (step_en) begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            read_valid_reg <= read_valid_next;
            skid_word_reg  <= skid_word_next;
            skid_full_reg  <= skid_full_next;
            occ_reg        <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && we) mem[wr_ptr_reg] <= step.push_data;
        if (step_en && re) read_word_reg <= mem[rd_ptr_reg];
    end

    assign res.head_data  = skid_full_reg ? skid_word_reg : read_word_reg;
    assign res.head_valid = head_valid;
    assign res.is_full    = full;
    assign res.is_empty   = empty;
    assign res.occupancy  = occ_reg;

`ifndef SYNTH
    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && full) |=> (wr_ptr_reg == $past(wr_ptr_reg)))
        else $error("write pointer moved while full");
    a_no_read_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && empty) |=> (rd_ptr_reg == $past(rd_ptr_reg)))
        else $error("read pointer moved while empty");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && step.flush) |=> (!head_valid && occ_reg == '0 &&
                                     rd_ptr_reg == $past(wr_ptr_reg)))
        else $error("flush left state behind");
`endif

endmodule

// File: hdl/pfifo_out.sv
// Result register between the FIFO core and the master stream port.
// Holds one result; loads whenever it is empty or being drained. Depends on pfifo_pkg.
module pfifo_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  pfifo_pkg::result_t            res,
    output logic                          load_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfifo_pkg::TDATA_W-1:0] m_tdata
);
    import pfifo_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign load_ready = ~valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_ready) data_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_W'(data_reg);

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |-> !load_ready)
        else $error("pending result could be overwritten");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && load_ready) |=> valid_reg)
        else $error("loaded result not presented");
    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_tready && !load) |=> !valid_reg)
        else $error("drained result still presented");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for prefetch_fifo_with_skid: a cycle-level predictor of the FIFO
// and its skid stage checks every result transfer. Depends on pfifo_pkg and the RTL in hdl/.
module testbench;
    import pfifo_pkg::*;

    typedef struct {
        result_t res;
        bit      data_known;  // head_data is meaningful only once the read word was loaded
    } fifo_expect_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    // predictor state
    word_t  fifo_mem [DEPTH];
    ptr_t   wr_ptr, rd_ptr;
    word_t  rd_word, skid_word;
    bit     rd_word_v, rd_word_known, skid_v;
    count_t occ;

    fifo_expect_t expected_outputs[$];

    int  errors        = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  flush_count   = 0;
    int  full_rejects  = 0;
    int  max_occ       = 0;
    bit  src_no_idle   = 1'b0;
    bit  snk_no_idle   = 1'b0;
    bit  hold_off_req  = 1'b0;
    bit  checking_on   = 1'b0;

    prefetch_fifo_with_skid u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic step_t make_step(int push_pct, int ready_pct, int flush_pct);
        step_t st;
        st.flush     = ($urandom_range(0, 999) < flush_pct);
        st.push_req  = ($urandom_range(0, 99) < push_pct);
        st.push_data = word_t'($urandom);
        st.pop_ready = ($urandom_range(0, 99) < ready_pct);
        return st;
    endfunction

    // One FIFO cycle: queue the outputs seen during it, then apply its inputs.
    function automatic void predict_fifo_outputs(step_t st);
        fifo_expect_t e;
        ptr_t  next_wr;
        bit    empty, full, hv, we, re, hs, nsv;
        word_t nsk;
        int    buffered;
        next_wr = wr_ptr + 1'b1;
        empty = (wr_ptr == rd_ptr);
        full  = (next_wr == rd_ptr);
        hv    = rd_word_v || skid_v;
        e.res.head_data  = skid_v ? skid_word : rd_word;
        e.res.head_valid = hv;
        e.res.is_full    = full;
        e.res.is_empty   = empty;
        e.res.occupancy  = occ;
        e.data_known     = skid_v || rd_word_known;
        expected_outputs.push_back(e);
        if (int'(occ) > max_occ) max_occ = int'(occ);

        if (st.flush) begin
            flush_count++;
            rd_ptr    = wr_ptr;
            occ       = '0;
            skid_word = '0;
            skid_v    = 1'b0;
            rd_word_v = 1'b0;
            return;
        end

        buffered = int'(skid_v) + int'(rd_word_v);
        we = st.push_req && !full;
        if (st.push_req && full) full_rejects++;
        re = 1'b0;
        if (!empty)
            re = st.pop_ready ? (buffered < 2) : (!skid_v && !rd_word_v);
        hs = st.pop_ready && hv;

        if (we && !hs) begin
            if (occ != COUNT_MAX) occ = occ + 1'b1;
        end else if (!we && hs) begin
            if (occ != '0) occ = occ - 1'b1;
        end

        // skid stage sees the read word from before the edge
        nsv = skid_v;
        nsk = skid_word;
        if (st.pop_ready && skid_v) nsv = 1'b0;
        if (rd_word_v && !(st.pop_ready && !skid_v)) begin
            nsv = 1'b1;
            nsk = rd_word;
        end
        skid_v    = nsv;
        skid_word = nsk;

        if (we) begin
            fifo_mem[wr_ptr] = st.push_data;
            wr_ptr = next_wr;
        end
        if (re) begin
            rd_word       = fifo_mem[rd_ptr];
            rd_word_known = 1'b1;
            rd_ptr        = rd_ptr + 1'b1;
        end
        rd_word_v = re;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_result(logic [TDATA_W-1:0] raw);
        result_t      got;
        fifo_expect_t e;
        got = raw;
        results_seen++;
        if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none actual %h", $time, raw);
            errors++;
            return;
        end
        e = expected_outputs.pop_front();
        if (e.data_known)
            compare_field("head_data", 32'(e.res.head_data), 32'(got.head_data));
        compare_field("head_valid", 32'(e.res.head_valid), 32'(got.head_valid));
        compare_field("is_full",    32'(e.res.is_full),    32'(got.is_full));
        compare_field("is_empty",   32'(e.res.is_empty),   32'(got.is_empty));
        compare_field("occupancy",  32'(e.res.occupancy),  32'(got.occupancy));
    endtask

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_step(step_t st);
        int gap;
        bit accepted;
        gap = pick_gap(src_no_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - $bits(step_t)){1'b0}}, st};
        do begin
            @(negedge aclk);
            accepted = s_tready;
            @(posedge aclk);
        end while (!accepted);
        items_sent++;
        predict_fifo_outputs(st);
    endtask

    // Result side: random stalls, plus a long counted hold-off on request.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (checking_on);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 79;
                m_tready     <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
            @(negedge aclk);
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                stall_left = pick_gap(snk_no_idle);
            end
        end
    end

    task automatic test_fill_to_full();
        step_t st;
        // ready held low: prefetch parks one word in the skid stage, memory fills up
        for (int i = 0; i < 17; i++) begin
            st = make_step(100, 0, 0);
            case (i)
                0: st.push_data = 16'h0000;
                1: st.push_data = 16'hFFFF;
                2: st.push_data = 16'hAAAA;
                3: st.push_data = 16'h5555;
                default: ;
            endcase
            send_step(st);
        end
    endtask

    task automatic test_drain_and_toggle();
        step_t st;
        st = make_step(0, 100, 0);
        send_step(st);
        st = make_step(0, 0, 0);
        send_step(st);
        st = make_step(100, 100, 0);   // push and pop in the same cycle
        send_step(st);
        st = make_step(0, 100, 0);
        send_step(st);
    endtask

    task automatic test_flush();
        step_t st;
        st = '{pop_ready: 1'b1, push_data: 16'hFFFF, push_req: 1'b1, flush: 1'b1};
        send_step(st);
        st = make_step(0, 0, 0);
        send_step(st);
    endtask

    task automatic test_random_traffic(int n_items);
        int push_pct, ready_pct, flush_pct;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            // each phase biases the FIFO toward filling, draining or churning
            case ($urandom_range(0, 3))
                0: begin push_pct = 90; ready_pct = 15; end
                1: begin push_pct = 15; ready_pct = 90; end
                2: begin push_pct = 60; ready_pct = 60; end
                default: begin push_pct = 50; ready_pct = 30; end
            endcase
            flush_pct   = ($urandom_range(0, 3) == 0) ? 60 : 5;
            src_no_idle = ($urandom_range(0, 3) == 0);
            snk_no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 40 && sent < n_items; i++) begin
                send_step(make_step(push_pct, ready_pct, flush_pct));
                sent++;
            end
        end
        src_no_idle = 1'b0;
        snk_no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        // result side holds off while transfers keep coming, so s_tready must drop
        src_no_idle  = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_step(make_step(80, 50, 0));
        src_no_idle = 1'b0;
    endtask

    initial begin : stimulus
        wr_ptr        = '0;
        rd_ptr        = '0;
        rd_word       = '0;
        skid_word     = '0;
        rd_word_v     = 1'b0;
        rd_word_known = 1'b0;
        skid_v        = 1'b0;
        occ           = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        checking_on = 1'b1;

        test_fill_to_full();
        test_drain_and_toggle();
        test_flush();
        test_random_traffic(230);
        test_backpressure();
        test_random_traffic(230);

        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d FIFO cycles, checked %0d results: %0d flushes, %0d pushes refused",
                 items_sent, results_seen, flush_count, full_rejects);
        $display("when full, peak occupancy %0d, with a long result-side hold-off", max_occ);
        if (errors == 0 && expected_outputs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("%0t: timeout, %0d results still expected", $time, expected_outputs.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
